[hdl/tsg_pkg.sv]
// shared types and constants of the test signal generator
`timescale 1ns / 1ps
package tsg_pkg;

  typedef enum logic [2:0] {
    MODE_SILENCE = 3'd0,
    MODE_IMPULSE = 3'd1,
    MODE_STEP    = 3'd2,
    MODE_SINE    = 3'd3,
    MODE_CHIRP   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_AMPLITUDE = 3'd1,
    REG_TUNING    = 3'd2,
    REG_SWEEP     = 3'd3,
    REG_COUNT     = 3'd4,
    REG_CHANNELS  = 3'd5
  } reg_idx_t;

  localparam int CFG_AW = 5;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] amplitude;
    logic [31:0]        start_tuning_word;
    logic signed [31:0] sweep_rate;
    logic [23:0]        sample_count;
    logic [3:0]         channel_count;
  } cfg_regs_t;

  // per-tick control that travels beside the sample through the pipeline
  typedef struct packed {
    logic [2:0] mode;
    logic       first;
    logic       last_smp;
    logic [3:0] last_ch;
  } tick_t;

  // quarter-wave polynomial coefficients, Q15
  localparam logic [15:0] POLY_A = 16'd51472;
  localparam logic [14:0] POLY_B = 15'd21024;
  localparam logic [11:0] POLY_C = 12'd2320;

  localparam logic signed [16:0] W_FULL = 17'sd32768;
  localparam logic [14:0]        Y_MAX  = 15'd32767;

endpackage

[hdl/test_signal_generator.sv]
// test signal generator top level: dds sine, chirp, impulse, step and silence source
//
//  channel | dir  | beat content
//  in_     | in   | tdata[0] restart
//  out_    | out  | tdata sample_value, channel_index; tlast last_channel; tuser last_sample
//  cfg_    | apb  | mode, amplitude, start_tuning_word, sweep_rate, sample_count, channel_count
//
// a tick gives channel_count beats (clamped to 1..MAX_CHANNELS), one per cycle while out_tready
// is high; the tick passes the five shape stages and the emitter register before its first beat
// leaves. ticks past sample_count are taken and give no beat.
// sine path is a five-stage pipeline, one multiplier per stage; stalls back up stage by stage.
// rst_n is synchronous; no clearing pass after reset.
`timescale 1ns / 1ps
module test_signal_generator #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int MAX_CHANNELS    = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+10)/8)*8-1:0]   out_tdata,  // sample_value, channel_index
  output logic                                out_tlast,
  output logic                                out_tuser,  // last_sample
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tsg_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import tsg_pkg::*;

  localparam int OUT_DW = ((SAMPLE_BITS + 10) / 8) * 8;

  cfg_regs_t                     regs;
  logic                          ph_valid, ph_ready;
  logic [SINE_TABLE_BITS-1:0]    ph_idx;
  tick_t                         ph_tick;
  logic                          sh_valid, sh_ready;
  logic signed [SAMPLE_BITS-1:0] sh_value;
  tick_t                         sh_tick;
  logic signed [SAMPLE_BITS-1:0] out_value;
  logic [2:0]                    out_channel;

  tsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  tsg_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .MAX_CHANNELS    (MAX_CHANNELS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs),
    .tick_valid (in_tvalid),
    .restart    (in_tdata[0]),
    .tick_ready (in_tready),
    .dn_valid   (ph_valid),
    .dn_idx     (ph_idx),
    .dn_tick    (ph_tick),
    .dn_ready   (ph_ready)
  );

  tsg_shape #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .amplitude (regs.amplitude),
    .up_valid  (ph_valid),
    .up_idx    (ph_idx),
    .up_tick   (ph_tick),
    .up_ready  (ph_ready),
    .dn_valid  (sh_valid),
    .dn_value  (sh_value),
    .dn_tick   (sh_tick),
    .dn_ready  (sh_ready)
  );

  tsg_emit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (sh_valid),
    .up_value     (sh_value),
    .up_tick      (sh_tick),
    .up_ready     (sh_ready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_value    (out_value),
    .out_channel  (out_channel),
    .out_last_ch  (out_tlast),
    .out_last_smp (out_tuser)
  );

  assign out_tdata = OUT_DW'({out_channel, out_value});

endmodule

[hdl/tsg_cfg.sv]
// configuration register file behind the apb port
`timescale 1ns / 1ps
module tsg_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsg_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tsg_pkg::cfg_regs_t          regs
);
  import tsg_pkg::*;

  cfg_regs_t regs_r;
  logic      wr_en;
  reg_idx_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.mode              <= MODE_SILENCE;
      regs_r.amplitude         <= 16'sd32767;
      regs_r.start_tuning_word <= 32'd0;
      regs_r.sweep_rate        <= 32'sd0;
      regs_r.sample_count      <= 24'd48000;
      regs_r.channel_count     <= 4'd2;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:      regs_r.mode              <= pwdata[2:0];
        REG_AMPLITUDE: regs_r.amplitude         <= pwdata[15:0];
        REG_TUNING:    regs_r.start_tuning_word <= pwdata;
        REG_SWEEP:     regs_r.sweep_rate        <= pwdata;
        REG_COUNT:     regs_r.sample_count      <= pwdata[23:0];
        REG_CHANNELS:  regs_r.channel_count     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:      prdata = {29'd0, regs_r.mode};
      REG_AMPLITUDE: prdata = {{16{regs_r.amplitude[15]}}, regs_r.amplitude};
      REG_TUNING:    prdata = regs_r.start_tuning_word;
      REG_SWEEP:     prdata = regs_r.sweep_rate;
      REG_COUNT:     prdata = {8'd0, regs_r.sample_count};
      REG_CHANNELS:  prdata = {28'd0, regs_r.channel_count};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

[hdl/tsg_phase.sv]
// sample index, phase accumulator and phase step, updated on each accepted tick
`timescale 1ns / 1ps
module tsg_phase #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int MAX_CHANNELS    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsg_pkg::cfg_regs_t         regs,
  input  logic                       tick_valid,
  input  logic                       restart,
  output logic                       tick_ready,
  output logic                       dn_valid,
  output logic [SINE_TABLE_BITS-1:0] dn_idx,
  output tsg_pkg::tick_t             dn_tick,
  input  logic                       dn_ready
);
  import tsg_pkg::*;

  logic [23:0]           index_r, index_nxt, index_eff;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt, phase_eff;
  logic [PHASE_BITS-1:0] step_r, step_nxt, step_eff;
  logic [PHASE_BITS-1:0] tw_p, sweep_p;
  logic [63:0]           tw_ext, sweep_ext;
  logic                  accept, active;
  logic [24:0]           index_inc;

  assign tick_ready = dn_ready;
  assign accept     = tick_valid && dn_ready;

  assign tw_ext    = 64'(regs.start_tuning_word);
  assign sweep_ext = 64'(regs.sweep_rate);
  assign tw_p      = tw_ext[PHASE_BITS-1:0];
  assign sweep_p   = sweep_ext[PHASE_BITS-1:0];

  assign index_eff = restart ? 24'd0 : index_r;
  assign phase_eff = restart ? '0 : phase_r;
  assign step_eff  = restart ? tw_p : step_r;
  assign active    = index_eff < regs.sample_count;
  assign index_inc = {1'b0, index_eff} + 25'd1;

  always_comb begin
    index_nxt = index_eff;
    phase_nxt = phase_eff;
    step_nxt  = step_eff;
    if (active) begin
      index_nxt = index_inc[23:0];
      case (regs.mode)
        MODE_SINE: phase_nxt = phase_eff + tw_p;
        MODE_CHIRP: begin
          phase_nxt = phase_eff + step_eff;
          step_nxt  = step_eff + sweep_p;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= 24'd0;
      phase_r <= '0;
      step_r  <= '0;
    end else if (accept) begin
      index_r <= index_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    dn_tick.mode     = regs.mode;
    dn_tick.first    = (index_eff == 24'd0);
    dn_tick.last_smp = (index_inc == {1'b0, regs.sample_count});
    // channel count clamped to 1..MAX_CHANNELS, kept as count minus one
    if (regs.channel_count == 4'd0)
      dn_tick.last_ch = 4'd0;
    else if (5'(regs.channel_count) > 5'(MAX_CHANNELS))
      dn_tick.last_ch = 4'(MAX_CHANNELS - 1);
    else
      dn_tick.last_ch = regs.channel_count - 4'd1;
  end

  assign dn_idx   = phase_eff[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign dn_valid = tick_valid && active;

endmodule

[hdl/tsg_shape.sv]
// quarter-wave sine polynomial, waveform select and amplitude scaling pipeline
`timescale 1ns / 1ps
module tsg_shape #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [15:0]            amplitude,
  input  logic                          up_valid,
  input  logic [SINE_TABLE_BITS-1:0]    up_idx,
  input  tsg_pkg::tick_t                up_tick,
  output logic                          up_ready,
  output logic                          dn_valid,
  output logic signed [SAMPLE_BITS-1:0] dn_value,
  output tsg_pkg::tick_t                dn_tick,
  input  logic                          dn_ready
);
  import tsg_pkg::*;

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int SH    = 31 - SAMPLE_BITS;
  localparam logic [QBITS:0]         QSIZE = (QBITS+1)'(1) << QBITS;
  localparam logic signed [33:0]     RND   = 34'(64'sd1 <<< (SH - 1));
  localparam logic signed [33:0]     SMAX  = 34'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [33:0]     SMIN  = -SMAX - 34'sd1;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic r1, r2, r3, r4, r5;

  // stage payloads
  logic [SINE_TABLE_BITS-1:0] idx1_r;
  tick_t                      tk1_r, tk2_r, tk3_r, tk4_r, tk5_r;
  logic [15:0]                x2_r, x3_r, x4_r;
  logic [15:0]                xx2_r, xx3_r;
  logic                       neg2_r, neg3_r, neg4_r;
  logic [14:0]                u3_r;
  logic [15:0]                a4_r;
  logic signed [16:0]         w5_r;

  // stage 1 logic
  logic [1:0]       quad;
  logic [QBITS:0]   pos;
  logic [15:0]      x1;
  logic [31:0]      xsq;
  // stage 2 logic
  logic [27:0]      cx;
  logic [14:0]      u2;
  // stage 3 logic
  logic [30:0]      ux;
  logic [15:0]      a3;
  // stage 4 logic
  logic [31:0]      ax;
  logic [16:0]      ymag;
  logic [14:0]      yc;
  logic signed [16:0] sine, w4;
  // stage 5 logic
  logic signed [33:0] prod, scaled, sat;

  assign r5       = !v5_r || dn_ready;
  assign r4       = !v4_r || r5;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign up_ready = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (r1) v1_r <= up_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
      if (r5) v5_r <= v4_r;
    end
  end

  // position in the quarter, mirrored in the second and fourth quarters
  assign quad = idx1_r[SINE_TABLE_BITS-1 -: 2];
  assign pos  = quad[0] ? (QSIZE - {1'b0, idx1_r[QBITS-1:0]}) : {1'b0, idx1_r[QBITS-1:0]};
  assign x1   = 16'(pos) << (15 - QBITS);
  assign xsq  = 32'(x1) * 32'(x1);

  assign cx = 28'(POLY_C) * 28'(xx2_r);
  assign u2 = POLY_B - {3'd0, cx[26:15]};

  assign ux = 31'(u3_r) * 31'(xx3_r);
  assign a3 = POLY_A - ux[30:15];

  assign ax   = 32'(a4_r) * 32'(x4_r);
  assign ymag = ax[31:15];
  assign yc   = (ymag > 17'(Y_MAX)) ? Y_MAX : ymag[14:0];
  assign sine = neg4_r ? -$signed({2'b00, yc}) : $signed({2'b00, yc});

  always_comb begin
    case (tk4_r.mode)
      MODE_IMPULSE: w4 = tk4_r.first ? W_FULL : 17'sd0;
      MODE_STEP:    w4 = W_FULL;
      MODE_SINE,
      MODE_CHIRP:   w4 = sine;
      default:      w4 = 17'sd0;
    endcase
  end

  assign prod   = 34'(amplitude) * 34'(w5_r) + RND;
  assign scaled = prod >>> SH;
  assign sat    = (scaled > SMAX) ? SMAX : ((scaled < SMIN) ? SMIN : scaled);

  always_ff @(posedge clk) begin
    if (r1) begin
      idx1_r <= up_idx;
      tk1_r  <= up_tick;
    end
    if (r2) begin
      x2_r   <= x1;
      xx2_r  <= xsq[30:15];
      neg2_r <= quad[1];
      tk2_r  <= tk1_r;
    end
    if (r3) begin
      x3_r   <= x2_r;
      xx3_r  <= xx2_r;
      u3_r   <= u2;
      neg3_r <= neg2_r;
      tk3_r  <= tk2_r;
    end
    if (r4) begin
      x4_r   <= x3_r;
      a4_r   <= a3;
      neg4_r <= neg3_r;
      tk4_r  <= tk3_r;
    end
    if (r5) begin
      w5_r  <= w4;
      tk5_r <= tk4_r;
    end
  end

  assign dn_valid = v5_r;
  assign dn_value = sat[SAMPLE_BITS-1:0];
  assign dn_tick  = tk5_r;

endmodule

[hdl/tsg_emit.sv]
// holds one finished sample and sends it once per channel
`timescale 1ns / 1ps
module tsg_emit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  input  logic signed [SAMPLE_BITS-1:0] up_value,
  input  tsg_pkg::tick_t                up_tick,
  output logic                          up_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic [2:0]                    out_channel,
  output logic                          out_last_ch,
  output logic                          out_last_smp
);
  import tsg_pkg::*;

  logic                          valid_r;
  logic [3:0]                    ch_r;
  logic signed [SAMPLE_BITS-1:0] value_r;
  tick_t                         tick_r;
  logic                          last_ch, take;

  assign last_ch  = (ch_r == tick_r.last_ch);
  assign take     = !valid_r || (out_ready && last_ch);
  assign up_ready = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ch_r    <= 4'd0;
    end else if (take) begin
      valid_r <= up_valid;
      ch_r    <= 4'd0;
    end else if (out_ready) begin
      ch_r <= ch_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value_r <= up_value;
      tick_r  <= up_tick;
    end
  end

  assign out_valid    = valid_r;
  assign out_value    = value_r;
  assign out_channel  = ch_r[2:0];
  assign out_last_ch  = last_ch;
  assign out_last_smp = tick_r.last_smp;

endmodule

[hdl/tsg_checker.sv]
// port-level checks of the test signal generator, bound to the top level
`timescale 1ns / 1ps
module tsg_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((SAMPLE_BITS+10)/8)*8-1:0] out_tdata,
  input logic                              out_tlast,
  input logic                              out_tuser
);

  logic [2:0] chan;
  logic       beat;

  assign chan = out_tdata[SAMPLE_BITS +: 3];
  assign beat = out_tvalid && out_tready;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled output beat changed");

  // inside a tick the next channel follows at once with the same sample
  a_next_chan: assert property (@(posedge clk) disable iff (!rst_n)
    beat && !out_tlast |=> out_tvalid && chan == $past(chan) + 3'd1
      && out_tdata[SAMPLE_BITS-1:0] == $past(out_tdata[SAMPLE_BITS-1:0])
      && out_tuser == $past(out_tuser))
    else $error("channel sequence broken inside a tick");

  // a new tick starts at channel zero
  a_first_chan: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(beat && out_tlast) && out_tvalid |-> chan == 3'd0)
    else $error("tick did not start at channel zero");

  // nothing is sent right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind test_signal_generator tsg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
